// ===== design/ir_soft_carrier_transmitter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// IR transmitter assertion macros
// Shorthand for clocked assertions with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef IR_SOFT_CARRIER_TRANSMITTER_UNIT_MACROS_SVH
`define IR_SOFT_CARRIER_TRANSMITTER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define IRSCT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// consequent checked in the cycle after the antecedent
`define IRSCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== design/irsct_pkg.sv =====
// ----------------------------------------------------------------------------
// IR transmitter package
// Types, codes and constants shared by the IR pulse/space transmitter.
// ----------------------------------------------------------------------------
package irsct_pkg;

   localparam int DUR_W   = 24;   // duration field width, microseconds
   localparam int ACC_W   = 35;   // signed 1/256 us accumulators
   localparam int ADJ_W   = 18;   // signed per-segment adjust terms
   localparam int OVER_W  = 16;   // overshoot carried into the next space

   // queue between front and back, depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam logic [QPTR_W:0] QCOUNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

   localparam logic [15:0] CARRIER_HIGH_RST = 16'd3368;
   localparam logic [15:0] CARRIER_LOW_RST  = 16'd3368;
   localparam logic [11:0] OVERHEAD_RST     = 12'd256;
   localparam logic        ENABLE_RST       = 1'b1;

   localparam logic [ADJ_W-1:0] Q8_HALF = ADJ_W'(128);
   localparam logic [ADJ_W-1:0] Q8_ONE  = ADJ_W'(256);

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_MARK  = 2'd1,
      OP_SPACE = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_CARRIER_HIGH = 2'd0,
      CSR_CARRIER_LOW  = 2'd1,
      CSR_OVERHEAD     = 2'd2,
      CSR_ENABLE       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CLS_NOP,
      CLS_TICK,
      CLS_MARK,
      CLS_SPACE
   } cls_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_CARRIER,
      MODE_PLAIN,
      MODE_SPACE
   } mode_type;

   typedef struct packed {
      cls_type          cls;
      logic [DUR_W-1:0] dur;
   } item_type;

   // adj = width - overhead + half, adjm = adj - 384 (short segment slack)
   typedef struct packed {
      logic [ADJ_W-1:0] adj_hi;
      logic [ADJ_W-1:0] adj_lo;
      logic [ADJ_W-1:0] adjm_hi;
      logic [ADJ_W-1:0] adjm_lo;
      logic [11:0]      ovh;
      logic             enable;
   } cfg_type;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic rejected;
   } res_type;

endpackage

// ===== design/ir_soft_carrier_transmitter_unit.sv =====
// ----------------------------------------------------------------------------
// IR soft carrier transmitter
// Pulse/space transmitter with a carrier built from timed high/low segments.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_opcode, req_duration_us
//  rsp      out        rsp_valid/rsp_stall  rsp_pin_level, rsp_busy_res, rsp_rejected
//  csr      in         csr_wr_en            csr_index, csr_wdata
//
//  One item per cycle while rsp is not stalled; an item that begins a carrier
//  segment (a mark start with the carrier on, or the tick that closes a segment)
//  holds the execution stage while the excess accumulator takes the segment width.
//  A result reaches rsp through the front item register, the queue and the
//  result register.
//  Synchronous reset clears all control state; no clearing pass.
//  A 4-item queue separates decode from execution, so a stalled rsp side
//  keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module ir_soft_carrier_transmitter_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic [irsct_pkg::DUR_W-1:0] req_duration_us,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_pin_level,
   output logic                        rsp_busy_res,
   output logic                        rsp_rejected,
   input  logic                        csr_wr_en,
   input  logic [1:0]                  csr_index,
   input  logic [15:0]                 csr_wdata
);
   import irsct_pkg::*;

   logic [15:0] high_ff, high_in;
   logic [15:0] low_ff, low_in;
   logic [11:0] ovh_ff, ovh_in;
   logic        enable_ff, enable_in;
   cfg_type     cfg_ff, cfg_in;

   logic     push_valid, push_ready, pop_valid, pop;
   item_type push_item, pop_item;
   res_type  rsp_res;

   always_comb begin
      high_in   = high_ff;
      low_in    = low_ff;
      ovh_in    = ovh_ff;
      enable_in = enable_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CARRIER_HIGH: high_in   = csr_wdata;
            CSR_CARRIER_LOW:  low_in    = csr_wdata;
            CSR_OVERHEAD:     ovh_in    = csr_wdata[11:0];
            CSR_ENABLE:       enable_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // per-segment terms, computed from the registered settings and registered again in cfg_ff
   always_comb begin
      cfg_in.adj_hi  = {2'd0, high_ff} - {6'd0, ovh_ff} + Q8_HALF;
      cfg_in.adj_lo  = {2'd0, low_ff} - {6'd0, ovh_ff} + Q8_HALF;
      cfg_in.adjm_hi = {2'd0, high_ff} - {6'd0, ovh_ff} - Q8_ONE;
      cfg_in.adjm_lo = {2'd0, low_ff} - {6'd0, ovh_ff} - Q8_ONE;
      cfg_in.ovh     = ovh_ff;
      cfg_in.enable  = enable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff   <= CARRIER_HIGH_RST;
         low_ff    <= CARRIER_LOW_RST;
         ovh_ff    <= OVERHEAD_RST;
         enable_ff <= ENABLE_RST;
      end else begin
         high_ff   <= high_in;
         low_ff    <= low_in;
         ovh_ff    <= ovh_in;
         enable_ff <= enable_in;
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   irsct_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_duration_us (req_duration_us),
      .push_valid      (push_valid),
      .push_item       (push_item),
      .push_ready      (push_ready)
   );

   irsct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   irsct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_pin_level = rsp_res.pin_level;
   assign rsp_busy_res  = rsp_res.busy_res;
   assign rsp_rejected  = rsp_res.rejected;

endmodule

// ===== design/irsct_front.sv =====
// ----------------------------------------------------------------------------
// IR transmitter front end
// Accepts request items, decodes the opcode and hands them to the queue.
// ----------------------------------------------------------------------------
module irsct_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_opcode,
   input  logic [irsct_pkg::DUR_W-1:0] req_duration_us,
   output logic                     push_valid,
   output irsct_pkg::item_type      push_item,
   input  logic                     push_ready
);
   import irsct_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;
   cls_type  cls;

   always_comb begin
      case (req_opcode)
         OP_TICK:  cls = CLS_TICK;
         OP_MARK:  cls = CLS_MARK;
         OP_SPACE: cls = CLS_SPACE;
         default:  cls = CLS_NOP;
      endcase
   end

   assign req_stall  = valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      valid_in = valid_ff && !push_ready;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = '{cls: cls, dur: req_duration_us};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ===== design/irsct_queue.sv =====
// ----------------------------------------------------------------------------
// IR transmitter item queue
// Short FIFO that decouples the decode stage from the execution stage.
// ----------------------------------------------------------------------------
module irsct_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  irsct_pkg::item_type push_item,
   output logic                push_ready,
   output logic                pop_valid,
   output irsct_pkg::item_type pop_item,
   input  logic                pop
);
   import irsct_pkg::*;

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCOUNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/irsct_back.sv =====
// ----------------------------------------------------------------------------
// IR transmitter execution stage
// Runs marks, spaces and carrier segments and registers one result per item.
// ----------------------------------------------------------------------------
module irsct_back (
   input  logic                clock,
   input  logic                reset,
   input  irsct_pkg::cfg_type  cfg,
   input  logic                pop_valid,
   input  irsct_pkg::item_type pop_item,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output irsct_pkg::res_type  rsp_res
);
   import irsct_pkg::*;

   mode_type                mode_ff, mode_in;
   logic                    level_ff, level_in;
   logic                    lpn_ff, lpn_in;
   logic [DUR_W-1:0]        ticks_ff, ticks_in;
   logic signed [ACC_W-1:0] slack_ff, slack_in;     // scheduled - elapsed
   logic signed [ACC_W-1:0] excess_ff, excess_in;   // elapsed - target
   logic [ACC_W-1:0]        pend_ff, pend_in;       // segment width still to add
   logic                    pend_v_ff, pend_v_in;
   logic [OVER_W-1:0]       over_ff, over_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   res_type                 rsp_ff, rsp_in;

   logic take, idle, is_cmd, rej;
   logic tick_done, tick_fire, tick_count;
   logic mark_go, space_go, seg_fresh, seg_again, seg_begin;
   logic lpn_base;
   logic [ADJ_W-1:0]        adj, adjm;
   logic signed [ACC_W-1:0] slack_base, x_sum, x_short, slack_seg, excess_seg;
   logic                    seg_long;
   logic [DUR_W-1:0]        seg_ticks;
   logic [ACC_W-1:0]        pend_seg;
   logic [OVER_W-1:0]       over_sat;
   logic [DUR_W:0]          space_diff;
   logic                    space_run;

   // the excess accumulator takes a segment's width in the cycle after it begins
   assign take = pop_valid && !pend_v_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop  = take;

   always_comb begin
      idle       = (mode_ff == MODE_IDLE);
      is_cmd     = (pop_item.cls == CLS_MARK) || (pop_item.cls == CLS_SPACE);
      rej        = take && is_cmd && !idle;
      tick_done  = (ticks_ff <= DUR_W'(1));
      tick_fire  = take && (pop_item.cls == CLS_TICK) && !idle && tick_done;
      tick_count = take && (pop_item.cls == CLS_TICK) && !idle && !tick_done;
      mark_go    = take && (pop_item.cls == CLS_MARK) && idle;
      space_go   = take && (pop_item.cls == CLS_SPACE) && idle;
      seg_fresh  = mark_go && (pop_item.dur != '0) && cfg.enable;
      seg_again  = tick_fire && (mode_ff == MODE_CARRIER) && excess_ff[ACC_W-1];
      seg_begin  = seg_fresh || seg_again;
   end

   // segment rounding
   always_comb begin
      lpn_base   = seg_fresh ? 1'b0 : lpn_ff;
      slack_base = seg_fresh ? '0 : slack_ff;
      adj        = lpn_base ? cfg.adj_lo : cfg.adj_hi;
      adjm       = lpn_base ? cfg.adjm_lo : cfg.adjm_hi;
      x_sum      = slack_base + $signed({{(ACC_W-ADJ_W){adj[ADJ_W-1]}}, adj});
      x_short    = slack_base + $signed({{(ACC_W-ADJ_W){adjm[ADJ_W-1]}}, adjm});
      seg_long   = !x_sum[ACC_W-1] && (x_sum[ACC_W-2:8] != '0);
      if (seg_long && (x_sum[DUR_W+7:8] != '0)) begin
         seg_ticks = x_sum[DUR_W+7:8];
      end else begin
         seg_ticks = DUR_W'(1);
      end
      if (seg_long) begin
         slack_seg = $signed({{(ACC_W-8){1'b0}}, x_sum[7:0]})
                   - $signed({{(ACC_W-ADJ_W){1'b0}}, Q8_HALF});
         pend_seg  = {x_sum[ACC_W-1:8], 8'd0};
      end else begin
         slack_seg = x_short;
         pend_seg  = {{(ACC_W-ADJ_W){1'b0}}, Q8_ONE};
      end
      if (seg_fresh) begin
         excess_seg = $signed({{(ACC_W-12){1'b0}}, cfg.ovh})
                    - $signed({{(ACC_W-DUR_W-8){1'b0}}, pop_item.dur, 8'd0});
      end else begin
         excess_seg = excess_ff + $signed({{(ACC_W-12){1'b0}}, cfg.ovh});
      end
      if (excess_ff[ACC_W-2:OVER_W+8] != '0) begin
         over_sat = '1;
      end else begin
         over_sat = excess_ff[OVER_W+7:8];
      end
      space_diff = {1'b0, pop_item.dur} - {{(DUR_W+1-OVER_W){1'b0}}, over_ff};
      space_run  = !space_diff[DUR_W] && (space_diff[DUR_W-1:0] != '0);
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_IDLE: begin
            if (mark_go && (pop_item.dur != '0)) begin
               mode_in = cfg.enable ? MODE_CARRIER : MODE_PLAIN;
            end else if (space_go && space_run) begin
               mode_in = MODE_SPACE;
            end
         end
         MODE_CARRIER: begin
            if (tick_fire && !excess_ff[ACC_W-1]) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_PLAIN, MODE_SPACE: begin
            if (tick_fire) begin
               mode_in = MODE_IDLE;
            end
         end
         default: mode_in = MODE_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      level_in  = level_ff;
      lpn_in    = lpn_ff;
      ticks_in  = ticks_ff;
      slack_in  = slack_ff;
      excess_in = excess_ff;
      pend_in   = pend_ff;
      pend_v_in = seg_begin;
      over_in   = over_ff;
      if (pend_v_ff) begin
         excess_in = excess_ff + $signed(pend_ff);
      end
      if (tick_count) begin
         ticks_in = ticks_ff - 1'b1;
      end
      if (seg_begin) begin
         level_in  = !lpn_base;
         lpn_in    = !lpn_base;
         ticks_in  = seg_ticks;
         slack_in  = slack_seg;
         excess_in = excess_seg;
         pend_in   = pend_seg;
      end else if (tick_fire) begin
         level_in = 1'b0;
         ticks_in = '0;
         if (mode_ff == MODE_CARRIER) begin
            over_in = over_sat;
         end else if (mode_ff == MODE_PLAIN) begin
            over_in = '0;
         end
      end else if (mark_go) begin
         // zero length mark ends at once, otherwise a plain mark
         level_in = (pop_item.dur != '0);
         ticks_in = pop_item.dur;
         over_in  = '0;
      end else if (space_go) begin
         level_in = 1'b0;
         ticks_in = space_run ? space_diff[DUR_W-1:0] : '0;
         over_in  = '0;
      end
   end

   // result register
   always_comb begin
      rsp_in.pin_level = level_in;
      rsp_in.busy_res  = (mode_in != MODE_IDLE);
      rsp_in.rejected  = rej;
      rsp_valid_in     = take || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         level_ff     <= 1'b0;
         lpn_ff       <= 1'b0;
         ticks_ff     <= '0;
         slack_ff     <= '0;
         excess_ff    <= '0;
         pend_v_ff    <= 1'b0;
         over_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         level_ff     <= level_in;
         lpn_ff       <= lpn_in;
         ticks_ff     <= ticks_in;
         slack_ff     <= slack_in;
         excess_ff    <= excess_in;
         pend_v_ff    <= pend_v_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== design/irsct_checker.sv =====
// ----------------------------------------------------------------------------
// IR transmitter port checker
// Watches the top level ports for result consistency and hold of stalled items.
// ----------------------------------------------------------------------------
`include "ir_soft_carrier_transmitter_unit_macros.svh"

module irsct_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_opcode,
   input logic [23:0] req_duration_us,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_pin_level,
   input logic        rsp_busy_res,
   input logic        rsp_rejected
);

   logic        req_held;
   logic [25:0] req_bits;
   logic        rsp_held;
   logic [2:0]  rsp_bits;

   assign req_held = req_valid && req_stall;
   assign req_bits = {req_opcode, req_duration_us};
   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_bits = {rsp_pin_level, rsp_busy_res, rsp_rejected};

   // a command is only turned away while something is running
   `IRSCT_ASSERT_IMPL(a_rej_busy, clock, reset, (rsp_valid && rsp_rejected), rsp_busy_res)

   // nothing running means the pin rests low
   `IRSCT_ASSERT_IMPL(a_idle_low, clock, reset, (rsp_valid && !rsp_busy_res), !rsp_pin_level)

   `IRSCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_bits))

   // a stalled request item stays put
   `IRSCT_ASSERT_NEXT(a_req_hold, clock, reset, req_held, req_valid && $stable(req_bits))

endmodule

bind ir_soft_carrier_transmitter_unit irsct_checker u_irsct_checker (.*);

// ===== sim/irsct_tx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR transmitter result checker
// Watches the request, response and register ports, keeps its own model of
// the pin/segment timing and compares every response with the oldest
// prediction.
// ----------------------------------------------------------------------------
module irsct_tx_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic [irsct_pkg::DUR_W-1:0] req_duration_us,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_pin_level,
   input  logic                        rsp_busy_res,
   input  logic                        rsp_rejected,
   input  logic                        csr_wr_en,
   input  logic [1:0]                  csr_index,
   input  logic [15:0]                 csr_wdata,
   output int                          fail_count,
   output int                          pending
);
   import irsct_pkg::*;

   localparam longint HALF_US_Q8 = 128;
   localparam longint ONE_US_Q8  = 256;

   // register copy
   logic [15:0]      cfg_high;
   logic [15:0]      cfg_low;
   logic [11:0]      cfg_ovh;
   logic             cfg_en;

   // transmitter state
   logic             lvl;
   mode_type         mode;
   logic             next_low;
   logic [DUR_W-1:0] remain;
   logic [63:0]      target_q8;
   logic [63:0]      spent_q8;
   logic [63:0]      planned_q8;
   logic [15:0]      carry_us;

   res_type          awaited_pin_res[$];
   int               errs = 0;
   int               item_no = 0;

   // start the next high or low carrier segment, rounded to whole us
   function automatic void open_segment();
      longint      slack;
      logic [63:0] seg_us;
      if (next_low) begin
         lvl        = 1'b0;
         planned_q8 = planned_q8 + 64'(cfg_low);
      end else begin
         lvl        = 1'b1;
         planned_q8 = planned_q8 + 64'(cfg_high);
      end
      slack = longint'(planned_q8) - longint'(spent_q8) - longint'(cfg_ovh) + HALF_US_Q8;
      if (slack < ONE_US_Q8)
         seg_us = 64'd1;
      else
         seg_us = 64'(slack) >> 8;
      remain = seg_us[DUR_W-1:0];
      if (remain == '0)
         remain = DUR_W'(1);
      spent_q8 = spent_q8 + (64'(remain) << 8) + 64'(cfg_ovh);
      next_low = ~next_low;
   endfunction

   function automatic void close_mark(input logic [15:0] over);
      lvl      = 1'b0;
      mode     = MODE_IDLE;
      remain   = '0;
      carry_us = over;
   endfunction

   function automatic res_type advance_transmitter(input logic [1:0]       op,
                                                   input logic [DUR_W-1:0] len);
      res_type     r;
      logic [63:0] over;
      r.rejected = 1'b0;
      if (op == OP_TICK) begin
         if (mode != MODE_IDLE) begin
            if (remain > 0)
               remain = remain - DUR_W'(1);
            if (remain == '0) begin
               if (mode == MODE_CARRIER) begin
                  if (spent_q8 < target_q8) begin
                     open_segment();
                  end else begin
                     over = (spent_q8 - target_q8) >> 8;
                     if (over > 64'hFFFF)
                        over = 64'hFFFF;
                     close_mark(over[15:0]);
                  end
               end else if (mode == MODE_PLAIN) begin
                  close_mark(16'd0);
               end else begin
                  mode = MODE_IDLE;
                  lvl  = 1'b0;
               end
            end
         end
      end else if (op == OP_MARK || op == OP_SPACE) begin
         if (mode != MODE_IDLE) begin
            r.rejected = 1'b1;
         end else if (op == OP_MARK) begin
            if (len == '0) begin
               close_mark(16'd0);
            end else if (cfg_en) begin
               mode       = MODE_CARRIER;
               target_q8  = 64'(len) << 8;
               spent_q8   = '0;
               planned_q8 = '0;
               next_low   = 1'b0;
               open_segment();
            end else begin
               mode   = MODE_PLAIN;
               lvl    = 1'b1;
               remain = len;
            end
         end else begin
            // overshoot of the last mark is taken off this space
            lvl = 1'b0;
            if (len > DUR_W'(carry_us)) begin
               remain = len - DUR_W'(carry_us);
               mode   = MODE_SPACE;
            end else begin
               remain = '0;
               mode   = MODE_IDLE;
            end
            carry_us = '0;
         end
      end
      r.pin_level = lvl;
      r.busy_res  = (mode != MODE_IDLE);
      return r;
   endfunction

   always @(posedge clock) begin
      res_type want;
      res_type got;
      if (reset) begin
         cfg_high   = CARRIER_HIGH_RST;
         cfg_low    = CARRIER_LOW_RST;
         cfg_ovh    = OVERHEAD_RST;
         cfg_en     = ENABLE_RST;
         lvl        = 1'b0;
         mode       = MODE_IDLE;
         next_low   = 1'b0;
         remain     = '0;
         target_q8  = '0;
         spent_q8   = '0;
         planned_q8 = '0;
         carry_us   = '0;
         awaited_pin_res.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_CARRIER_HIGH: cfg_high = csr_wdata;
               CSR_CARRIER_LOW:  cfg_low  = csr_wdata;
               CSR_OVERHEAD:     cfg_ovh  = csr_wdata[11:0];
               CSR_ENABLE:       cfg_en   = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got.pin_level = rsp_pin_level;
            got.busy_res  = rsp_busy_res;
            got.rejected  = rsp_rejected;
            item_no++;
            if (awaited_pin_res.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("response %0d with nothing outstanding: pin=%b busy=%b rej=%b",
                           item_no, got.pin_level, got.busy_res, got.rejected);
            end else begin
               want = awaited_pin_res.pop_front();
               if (got.pin_level !== want.pin_level || got.busy_res !== want.busy_res ||
                   got.rejected !== want.rejected) begin
                  errs++;
                  if (errs <= 10)
                     $display({"response %0d mismatch: expected pin=%b busy=%b rej=%b,",
                               " got pin=%b busy=%b rej=%b"},
                              item_no, want.pin_level, want.busy_res, want.rejected,
                              got.pin_level, got.busy_res, got.rejected);
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_pin_res.push_back(advance_transmitter(req_opcode, req_duration_us));
      end
      fail_count <= errs;
      pending    <= awaited_pin_res.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR soft carrier transmitter testbench
// Drives ticks, marks and spaces under a series of carrier settings, with
// bursty requests and a stalling response side; the checker predicts and
// compares every response.
// ----------------------------------------------------------------------------
module tb;
   import irsct_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN       = 20;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [1:0]       req_opcode = 2'd0;
   logic [DUR_W-1:0] req_duration_us = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_pin_level;
   logic             rsp_busy_res;
   logic             rsp_rejected;
   logic             csr_wr_en = 1'b0;
   logic [1:0]       csr_index = 2'd0;
   logic [15:0]      csr_wdata = '0;

   int               fail_count;
   int               pending;
   int               cycle_count = 0;
   int               sent = 0;
   int               burst_left = 0;
   logic             hold_req = 1'b0;

   // local view of the registers, only used to size tick runs
   int               tb_high = 3368;
   int               tb_low  = 3368;
   int               tb_en   = 1;

   always #1 clock = ~clock;

   ir_soft_carrier_transmitter_unit u_top (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_opcode,
      .req_duration_us,
      .rsp_valid,
      .rsp_stall,
      .rsp_pin_level,
      .rsp_busy_res,
      .rsp_rejected,
      .csr_wr_en,
      .csr_index,
      .csr_wdata
   );

   irsct_tx_checker u_chk (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_opcode,
      .req_duration_us,
      .rsp_valid,
      .rsp_stall,
      .rsp_pin_level,
      .rsp_busy_res,
      .rsp_rejected,
      .csr_wr_en,
      .csr_index,
      .csr_wdata,
      .fail_count,
      .pending
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side: shifting stall patterns, plus one long hold-off on request
   initial begin
      int  hold_left;
      int  pat_left;
      int  pat_mode;
      bit  hold_done;
      hold_left = 0;
      pat_left  = 0;
      pat_mode  = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 300;
            rsp_stall <= 1'b1;
         end else begin
            if (pat_left == 0) begin
               pat_mode = $urandom_range(3);
               pat_left = $urandom_range(80, 8);
            end
            pat_left--;
            case (pat_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(99) < 30);
               2: rsp_stall <= ($urandom_range(99) < 70);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input opcode_type op, input logic [DUR_W-1:0] dur);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(6, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_duration_us <= dur;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   // upper bits of the narrow registers carry junk
   task automatic apply_setting(input int h, input int l, input int o, input int e);
      write_reg(CSR_CARRIER_HIGH, 16'(h));
      write_reg(CSR_CARRIER_LOW, 16'(l));
      write_reg(CSR_OVERHEAD, {4'($urandom), 12'(o)});
      write_reg(CSR_ENABLE, {15'($urandom), 1'(e)});
      csr_wr_en <= 1'b0;
      tb_high = h;
      tb_low  = l;
      tb_en   = e;
   endtask

   // mostly complete mark/space sequences, some cut short, some noise
   task automatic run_phase(input int budget);
      int stop;
      int r;
      int len;
      int need;
      int n;
      stop = sent + budget;
      while (sent < stop) begin
         r = $urandom_range(99);
         if (r < 50) begin
            len = ($urandom_range(9) == 0) ? 0 : $urandom_range(24, 1);
            send_item(OP_MARK, DUR_W'(len));
            // a command straight after a running mark start is always refused
            if (len > 0 && $urandom_range(9) < 3)
               send_item($urandom_range(1) ? OP_MARK : OP_SPACE, DUR_W'($urandom));
            if (tb_en != 0)
               need = len + (((tb_high > tb_low) ? tb_high : tb_low) >> 8) + 2;
            else
               need = len;
         end else if (r < 85) begin
            len = $urandom_range(28);
            send_item(OP_SPACE, DUR_W'(len));
            need = len;
         end else begin
            send_item($urandom_range(1) ? OP_NOP : OP_TICK, DUR_W'($urandom));
            need = $urandom_range(3);
         end
         n = ($urandom_range(4) == 0) ? $urandom_range(need) : need + $urandom_range(3);
         repeat (n) send_item(OP_TICK, DUR_W'($urandom));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset carrier settings
      send_item(OP_NOP, 24'hFFFFFF);
      send_item(OP_TICK, 24'h000000);
      send_item(OP_SPACE, 24'd0);
      send_item(OP_MARK, 24'd0);
      send_item(OP_MARK, 24'd5);
      send_item(OP_MARK, 24'hFFFFFF);
      send_item(OP_SPACE, 24'hAAAAAA);
      send_item(OP_NOP, 24'h555555);
      repeat (12) send_item(OP_TICK, DUR_W'($urandom));
      send_item(OP_SPACE, 24'd4);   // swallowed by the overshoot
      send_item(OP_SPACE, 24'd2);
      repeat (3) send_item(OP_TICK, 24'hFFFFFF);

      run_phase(220);
      wait_idle();

      // segments shorter than the overhead
      apply_setting(1, 1, 4095, 1);
      run_phase(200);
      wait_idle();

      // carrier off; response side holds off early in this phase
      apply_setting($urandom_range(4000, 1), $urandom_range(4000, 1),
                    $urandom_range(4095), 0);
      hold_req = 1'b1;
      run_phase(200);
      wait_idle();

      // widest segments, no overhead
      apply_setting(65535, 65535, 0, 1);
      run_phase(300);
      wait_idle();

      // width equal to the overhead on the high side
      apply_setting(300, 200, 300, 1);
      run_phase(200);
      wait_idle();

      repeat (2) begin
         apply_setting($urandom_range(3000, 1), $urandom_range(3000, 1),
                       $urandom_range(4095), $urandom_range(1));
         run_phase(180);
         wait_idle();
      end

      // longest mark last, it never finishes within the run
      repeat (40) send_item(OP_TICK, DUR_W'($urandom));
      send_item(OP_MARK, 24'hFFFFFF);
      repeat (3) send_item(OP_TICK, DUR_W'($urandom));
      send_item(OP_SPACE, 24'hFFFFFF);
      send_item(OP_NOP, 24'h000000);
      wait_idle();

      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
